/* rtl/core/gima_pkg.sv */
// Shared types, constants and modular helpers for the Gaussian integer mod ALU.
package gima_pkg;

    localparam int PART_W     = 30;
    localparam int PROD_W     = 2 * PART_W;
    localparam int RED_STAGES = PART_W;

    localparam logic [PART_W-1:0] MODULUS_RESET = PART_W'(12289);

    typedef logic [PART_W-1:0] t_part;
    typedef logic [PROD_W-1:0] t_prod;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2
    } t_action;

    // data that rides along the reduction pipeline
    typedef struct packed {
        logic    valid;
        t_action act;
        logic    bad;
        t_part   zr_as;
        t_part   zi_as;
    } t_side;

    function automatic t_part mod_add(input t_part a, input t_part b, input t_part q);
        logic [PART_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, q}) begin
            s = s - {1'b0, q};
        end
        return s[PART_W-1:0];
    endfunction

    function automatic t_part mod_sub(input t_part a, input t_part b, input t_part q);
        logic [PART_W:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + {1'b0, q} - {1'b0, b};
        end
        return s[PART_W-1:0];
    endfunction

endpackage

/* rtl/core/gaussian_integer_mod_alu_unit.sv */
// Top level of the pipelined Gaussian integer modular ALU.
//
// Usage: an operation is accepted on a rising edge with start high and busy
// low. busy is never raised, so one operation may enter every cycle.
// Each operation carries action (add, subtract, multiply) and two Gaussian
// integers x and y with parts below the modulus q.
// The result appears on o_z_real / o_z_imag / o_operand_error for exactly
// one cycle, flagged by o_valid; results come out in order. Latency is
// set by the 30-stage bit-per-stage modular reduction that follows the
// three 30x30 multipliers; add and subtract ride the same pipeline so every
// action has the same latency.
// Throughput: one operation per cycle.
// The user must write the modulus with i_cfg_we / i_cfg_wdata only while
// no operation is in flight; the block does not enforce this. Reset
// (synchronous, active low) flushes the pipeline valids and loads the
// modulus with 12289. The receiver cannot stall the output.
// An operand part at or above q gives o_operand_error with zero parts.
module gaussian_integer_mod_alu_unit import gima_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [PART_W-1:0] i_cfg_wdata,
    input  logic [1:0]        i_action,
    input  logic [PART_W-1:0] i_x_real,
    input  logic [PART_W-1:0] i_x_imag,
    input  logic [PART_W-1:0] i_y_real,
    input  logic [PART_W-1:0] i_y_imag,
    output logic              o_valid,
    output logic [PART_W-1:0] o_z_real,
    output logic [PART_W-1:0] o_z_imag,
    output logic              o_operand_error
);

    t_part r_modulus;

    // stage 1
    logic    r_v1;
    t_action r_act1;
    logic    r_bad1;
    t_part   r_xr1, r_xi1, r_yr1, r_yi1;

    // stage 2
    t_side   r_sd2;
    t_part   r_xr2, r_xi2, r_yr2, r_yi2, r_sx2, r_sy2;

    // stage 3
    t_side   r_sd3;
    t_prod   r_p1, r_p2, r_p3;

    t_side   r_side [RED_STAGES];
    t_part   w_s1, w_s2, w_s3;

    t_side   n_sd2;
    logic    n_bad;
    t_part   n_zr, n_zi, w_t;

    logic    r_out_v;
    t_part   r_zr, r_zi;
    logic    r_err;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    assign n_bad = (i_x_real >= r_modulus) || (i_x_imag >= r_modulus) ||
                   (i_y_real >= r_modulus) || (i_y_imag >= r_modulus);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
        end
        r_act1 <= t_action'(i_action);
        r_bad1 <= n_bad;
        r_xr1  <= i_x_real;
        r_xi1  <= i_x_imag;
        r_yr1  <= i_y_real;
        r_yi1  <= i_y_imag;
    end

    always_comb begin
        n_sd2.valid = r_v1;
        n_sd2.act   = r_act1;
        n_sd2.bad   = r_bad1;
        case (r_act1)
            ACT_ADD: begin
                n_sd2.zr_as = mod_add(r_xr1, r_yr1, r_modulus);
                n_sd2.zi_as = mod_add(r_xi1, r_yi1, r_modulus);
            end
            ACT_SUB: begin
                n_sd2.zr_as = mod_sub(r_xr1, r_yr1, r_modulus);
                n_sd2.zi_as = mod_sub(r_xi1, r_yi1, r_modulus);
            end
            default: begin
                n_sd2.zr_as = '0;
                n_sd2.zi_as = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd2 <= '0;
        end else begin
            r_sd2 <= n_sd2;
        end
        r_xr2 <= r_xr1;
        r_xi2 <= r_xi1;
        r_yr2 <= r_yr1;
        r_yi2 <= r_yi1;
        r_sx2 <= mod_add(r_xr1, r_xi1, r_modulus);
        r_sy2 <= mod_add(r_yr1, r_yi1, r_modulus);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd3 <= '0;
        end else begin
            r_sd3 <= r_sd2;
        end
        r_p1 <= {{PART_W{1'b0}}, r_xr2} * {{PART_W{1'b0}}, r_yr2};
        r_p2 <= {{PART_W{1'b0}}, r_xi2} * {{PART_W{1'b0}}, r_yi2};
        r_p3 <= {{PART_W{1'b0}}, r_sx2} * {{PART_W{1'b0}}, r_sy2};
    end

    gima_modred u_red_s1 (.i_clk(i_clk), .i_modulus(r_modulus), .i_prod(r_p1), .o_rem(w_s1));
    gima_modred u_red_s2 (.i_clk(i_clk), .i_modulus(r_modulus), .i_prod(r_p2), .o_rem(w_s2));
    gima_modred u_red_s3 (.i_clk(i_clk), .i_modulus(r_modulus), .i_prod(r_p3), .o_rem(w_s3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else begin
            r_side[0] <= r_sd3;
        end
    end

    for (genvar k = 1; k < RED_STAGES; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign w_t = mod_sub(w_s3, w_s1, r_modulus);

    always_comb begin
        n_zr = '0;
        n_zi = '0;
        if (!r_side[RED_STAGES-1].bad) begin
            case (r_side[RED_STAGES-1].act)
                ACT_ADD, ACT_SUB: begin
                    n_zr = r_side[RED_STAGES-1].zr_as;
                    n_zi = r_side[RED_STAGES-1].zi_as;
                end
                ACT_MUL: begin
                    n_zr = mod_sub(w_s1, w_s2, r_modulus);
                    n_zi = mod_sub(w_t, w_s2, r_modulus);
                end
                default: begin
                    n_zr = '0;
                    n_zi = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_side[RED_STAGES-1].valid;
        end
        r_zr  <= n_zr;
        r_zi  <= n_zi;
        r_err <= r_side[RED_STAGES-1].bad;
    end

    assign o_valid         = r_out_v;
    assign o_z_real        = r_zr;
    assign o_z_imag        = r_zi;
    assign o_operand_error = r_err;

    // a flagged beat carries zero parts
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_operand_error |-> o_z_real == '0 && o_z_imag == '0)
        else $error("operand error with nonzero result");

    // every result traces back to an accepted beat at fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 34))
        else $error("result without matching accepted beat");

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

/* rtl/core/gima_modred.sv */
// Pipelined restoring reduction of a 60-bit product modulo q, one bit per stage.
module gima_modred import gima_pkg::*; (
    input  logic  i_clk,
    input  t_part i_modulus,
    input  t_prod i_prod,
    output t_part o_rem
);

    t_part r_rem [RED_STAGES];
    t_part r_low [RED_STAGES];

    function automatic t_part red_step(input t_part rem, input logic b, input t_part q);
        logic [PART_W:0] sh;
        sh = {rem, b};
        if (sh >= {1'b0, q}) begin
            sh = sh - {1'b0, q};
        end
        return sh[PART_W-1:0];
    endfunction

    // product < q*2^30, so the upper half already sits below q
    always_ff @(posedge i_clk) begin
        r_rem[0] <= red_step(i_prod[PROD_W-1:PART_W], i_prod[PART_W-1], i_modulus);
        r_low[0] <= {i_prod[PART_W-2:0], 1'b0};
    end

    for (genvar k = 1; k < RED_STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_rem[k] <= red_step(r_rem[k-1], r_low[k-1][PART_W-1], i_modulus);
            r_low[k] <= {r_low[k-1][PART_W-2:0], 1'b0};
        end
    end

    assign o_rem = r_rem[RED_STAGES-1];

endmodule
